### sv/gfwq_pkg.sv
// shared types, constants and codes of the gated frequency window qualifier
package gfwq_pkg;

  localparam int TICK_WRAP_BITS = 36;
  localparam int TICKS_PER_US   = 16;
  localparam int TPU_SHIFT      = $clog2(TICKS_PER_US);
  localparam int TICK_W         = 36;
  localparam int CLOSE_W        = TICK_W + 1;
  localparam int SPAN_W         = CLOSE_W - TPU_SHIFT;
  localparam int ELAPSED_W      = TICK_W - TPU_SHIFT;
  localparam int KHZ_W          = 20;
  localparam int PROD_W         = KHZ_W + ELAPSED_W;
  localparam int EPROD_W        = KHZ_W + SPAN_W;
  localparam int WSUM_W         = 64;
  localparam int DUR_W          = 40;
  localparam int EDGES_W        = 42;
  localparam int CNT_W          = 32;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 8;

  localparam int DIV_DEND_W     = 64;
  localparam int DIV_DSR_W      = 40;
  localparam int DIV_BITS_CYC   = 2;
  localparam int DIV_CYCLES     = DIV_DEND_W / DIV_BITS_CYC;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
  localparam int EDGE_DIVISOR   = 1000;

  // edge product over 1000 in two halves: floor(n / 1000) = (n * EDGE_RECIP) >> 38
  // is exact for any 32-bit n
  localparam int EDGE_LO_W      = 21;
  localparam int EDGE_HI_W      = EPROD_W - EDGE_LO_W;
  localparam int EDGE_REM_W     = 10;
  localparam int EDGE_KQ_W      = 23;
  localparam int EDGE_KY_W      = EDGE_REM_W + EDGE_LO_W;
  localparam int EDGE_SHIFT     = 38;
  localparam logic [31:0] EDGE_RECIP = 32'h1062_4DD3;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_START = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_LEN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_READY_CLEAN   = CFG_IDX_W'(3);

  localparam logic [1:0] HEALTH_CLEAN     = 2'd0;
  localparam logic [1:0] HEALTH_SOME_ZERO = 2'd1;
  localparam logic [1:0] HEALTH_ALL_ZERO  = 2'd2;

  typedef struct packed {
    logic [KHZ_W-1:0]  sample_khz;
    logic [TICK_W-1:0] sample_open_ticks;
    logic [TICK_W-1:0] sample_close_ticks;
    logic [31:0]       now_ms;
  } sample_t;

  typedef struct packed {
    logic [TICK_W-1:0]  window_open_ticks;
    logic [CLOSE_W-1:0] window_close_ticks;
    logic [EDGES_W-1:0] edge_total;
    logic [KHZ_W-1:0]   average_khz;
    logic [SPAN_W-1:0]  span_us;
    logic [1:0]         health_code;
    logic               ctrl_ready;
    logic               fault_flag;
    logic               inhibit_active;
    logic [CNT_W-1:0]   bad_window_run;
    logic [KHZ_W-1:0]   min_khz;
    logic [KHZ_W-1:0]   max_khz;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] gate_len_us;
    logic [CFG_W-1:0] inhibit_start_ms;
    logic [CFG_W-1:0] inhibit_len_ms;
    logic [CFG_W-1:0] ready_clean_windows;
  } cfg_t;

  typedef struct packed {
    sample_t              smp;
    logic [ELAPSED_W-1:0] smp_len_us;
  } qent_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_DEND_W-1:0] dividend;
    logic [DIV_DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_DEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_CLOSE,
    ST_DIV1,
    ST_MUL2,
    ST_EDGE_HI,
    ST_EDGE_REM,
    ST_EDGE_LO,
    ST_OUT
  } back_state_e;

endpackage

### sv/gfwq_stream_if.sv
// valid/ready stream interface with a typed payload
interface gfwq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/gfwq_front.sv
// front end: sample transfer, duration extraction and the sample queue
module gfwq_front #(
  parameter int QUEUE_DEPTH = gfwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gfwq_stream_if.sink           sample_i,
  output logic                  q_valid_o,
  output gfwq_pkg::qent_t       q_data_o,
  input  logic                  q_pop_i
);
  import gfwq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  qent_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]  count_q, count_d;
  logic               push, pop;
  logic [TICK_W-1:0]  diff;
  qent_t              ent;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign sample_i.ready = (count_q != CNT_QW'(QUEUE_DEPTH));
  assign push = sample_i.valid && sample_i.ready;
  assign pop  = q_pop_i && (count_q != '0);

  // tick difference wraps at the field width, then whole microseconds
  assign diff = sample_i.data.sample_close_ticks - sample_i.data.sample_open_ticks;
  always_comb begin
    ent.smp        = sample_i.data;
    ent.smp_len_us = diff[TICK_W-1:TPU_SHIFT];
  end

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_QW'(push) - CNT_QW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_data_o  = mem_q[rd_ptr_q];

endmodule

### sv/gfwq_div.sv
// restoring divider, two quotient bits a cycle
module gfwq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gfwq_pkg::div_req_t  req_i,
  output gfwq_pkg::div_rsp_t  rsp_o
);
  import gfwq_pkg::*;

  logic                  busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_DSR_W-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [DIV_DEND_W-1:0] quo_q, quo_d;

  always_comb begin
    logic [DIV_DSR_W:0]    shifted;
    logic [DIV_DSR_W-1:0]  r;
    logic [DIV_DEND_W-1:0] qv;
    r       = rem_q;
    qv      = quo_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dsr_d   = dsr_q;
    for (int i = 0; i < DIV_BITS_CYC; i++) begin
      shifted = {r, qv[DIV_DEND_W-1]};
      if (shifted >= {1'b0, dsr_q}) begin
        shifted = shifted - {1'b0, dsr_q};
        qv      = {qv[DIV_DEND_W-2:0], 1'b1};
      end else begin
        qv      = {qv[DIV_DEND_W-2:0], 1'b0};
      end
      r = shifted[DIV_DSR_W-1:0];
    end
    rem_d = rem_q;
    quo_d = quo_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = r;
      quo_d = qv;
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### sv/gfwq_back.sv
// back end: window accumulation, close check, averaging and control gate
module gfwq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gfwq_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  gfwq_pkg::qent_t  q_data_i,
  output logic             q_pop_o,
  gfwq_stream_if.source    result_o
);
  import gfwq_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  back_state_e          state_q, state_d;
  logic                 win_open_q, win_open_d;
  logic [TICK_W-1:0]    start_q, start_d;
  logic [WSUM_W-1:0]    wsum_q, wsum_d;
  logic [DUR_W-1:0]     dur_q, dur_d;
  logic [CNT_W-1:0]     smp_tot_q, smp_tot_d, zero_tot_q, zero_tot_d;
  logic [KHZ_W-1:0]     min_q, min_d, max_q, max_d;
  logic [CNT_W-1:0]     clean_q, clean_d, bad_q, bad_d;
  logic                 fault_q, fault_d, ready_q, ready_d;
  qent_t                cur_q, cur_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [CLOSE_W-1:0]   close_q, close_d;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic [KHZ_W-1:0]     avg_q, avg_d;
  logic [EPROD_W-1:0]   eprod_q, eprod_d;
  logic [EDGE_KQ_W-1:0] kq_q, kq_d;
  logic [EDGE_KY_W-1:0] ky_q, ky_d;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  gfwq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic [WSUM_W:0]       wadd;
    logic [DUR_W:0]        dadd;
    logic [CLOSE_W-1:0]    ce;
    logic [CLOSE_W-1:0]    sdiff;
    logic                  win_ok, inh;
    logic [CFG_W-1:0]      since;
    logic [CNT_W-1:0]      cl;
    logic                  rdy;
    logic [63:0]           m1, m2;
    logic [EDGE_HI_W-1:0]  rr;
    logic [EDGE_LO_W-1:0]  q2;
    state_d     = state_q;
    win_open_d  = win_open_q;
    start_d     = start_q;
    wsum_d      = wsum_q;
    dur_d       = dur_q;
    smp_tot_d   = smp_tot_q;
    zero_tot_d  = zero_tot_q;
    min_d       = min_q;
    max_d       = max_q;
    clean_d     = clean_q;
    bad_d       = bad_q;
    fault_d     = fault_q;
    ready_d     = ready_q;
    cur_d       = cur_q;
    prod_d      = prod_q;
    close_d     = close_q;
    span_d      = span_q;
    avg_d       = avg_q;
    eprod_d     = eprod_q;
    kq_d        = kq_q;
    ky_d        = ky_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    div_req     = '0;
    wadd  = {1'b0, wsum_q} + (WSUM_W + 1)'(prod_q);
    dadd  = {1'b0, dur_q} + (DUR_W + 1)'(cur_q.smp_len_us);
    ce    = {1'b0, cur_q.smp.sample_close_ticks};
    if (cur_q.smp.sample_close_ticks < start_q) begin
      ce = ce + (CLOSE_W'(1) << TICK_WRAP_BITS);
    end
    sdiff  = ce - {1'b0, start_q};
    win_ok = (smp_tot_q != '0) && (zero_tot_q == '0);
    since  = cur_q.smp.now_ms - cfg_i.inhibit_start_ms;
    inh    = since < cfg_i.inhibit_len_ms;
    cl     = (clean_q == CNT_MAX) ? clean_q : clean_q + CNT_W'(1);
    rdy    = cl >= cfg_i.ready_clean_windows;
    // edge product over 1000: upper half first, then remainder joined to the lower bits
    m1     = 64'(eprod_q[EPROD_W-1:EDGE_LO_W]) * 64'(EDGE_RECIP);
    rr     = eprod_q[EPROD_W-1:EDGE_LO_W] - EDGE_HI_W'(kq_q) * EDGE_HI_W'(EDGE_DIVISOR);
    m2     = 64'(ky_q) * 64'(EDGE_RECIP);
    q2     = m2[EDGE_SHIFT+EDGE_LO_W-1:EDGE_SHIFT];
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          prod_d  = PROD_W'(q_data_i.smp.sample_khz) * PROD_W'(q_data_i.smp_len_us);
          if (!win_open_q) begin
            win_open_d = 1'b1;
            start_d    = q_data_i.smp.sample_open_ticks;
            wsum_d     = '0;
            dur_d      = '0;
            smp_tot_d  = '0;
            zero_tot_d = '0;
            min_d      = '0;
            max_d      = '0;
          end
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        wsum_d = wadd[WSUM_W] ? '1 : wadd[WSUM_W-1:0];
        dur_d  = dadd[DUR_W] ? '1 : dadd[DUR_W-1:0];
        if (smp_tot_q == '0) begin
          min_d = cur_q.smp.sample_khz;
          max_d = cur_q.smp.sample_khz;
        end else begin
          if (cur_q.smp.sample_khz < min_q) min_d = cur_q.smp.sample_khz;
          if (cur_q.smp.sample_khz > max_q) max_d = cur_q.smp.sample_khz;
        end
        smp_tot_d = (smp_tot_q == CNT_MAX) ? smp_tot_q : smp_tot_q + CNT_W'(1);
        if (cur_q.smp.sample_khz == '0 && zero_tot_q != CNT_MAX) begin
          zero_tot_d = zero_tot_q + CNT_W'(1);
        end
        close_d = ce;
        span_d  = sdiff[CLOSE_W-1:TPU_SHIFT];
        if (sdiff[CLOSE_W-1:TPU_SHIFT] < SPAN_W'(cfg_i.gate_len_us)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (dur_q == '0) begin
          avg_d   = '0;
          state_d = ST_MUL2;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = wsum_q;
          div_req.divisor  = dur_q;
          state_d          = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          avg_d   = (|div_rsp.quotient[DIV_DEND_W-1:KHZ_W]) ? '1
                                                           : div_rsp.quotient[KHZ_W-1:0];
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        eprod_d = EPROD_W'(avg_q) * EPROD_W'(span_q);
        state_d = ST_EDGE_HI;
      end
      ST_EDGE_HI: begin
        kq_d    = m1[EDGE_SHIFT+EDGE_KQ_W-1:EDGE_SHIFT];
        state_d = ST_EDGE_REM;
      end
      ST_EDGE_REM: begin
        ky_d    = {rr[EDGE_REM_W-1:0], eprod_q[EDGE_LO_W-1:0]};
        state_d = ST_EDGE_LO;
      end
      ST_EDGE_LO: begin
        res_d.window_open_ticks  = start_q;
        res_d.window_close_ticks = close_q;
        res_d.edge_total         = (|kq_q[EDGE_KQ_W-1:EDGE_LO_W]) ? '1
                                   : {kq_q[EDGE_LO_W-1:0], q2};
        res_d.average_khz        = avg_q;
        res_d.span_us            = span_q;
        if (zero_tot_q == '0) begin
          res_d.health_code = HEALTH_CLEAN;
        end else if (zero_tot_q == smp_tot_q) begin
          res_d.health_code = HEALTH_ALL_ZERO;
        end else begin
          res_d.health_code = HEALTH_SOME_ZERO;
        end
        if (!win_ok) begin
          clean_d = '0;
          ready_d = 1'b0;
          if (!inh) fault_d = 1'b1;
        end else if (inh) begin
          clean_d = '0;
          ready_d = 1'b0;
        end else begin
          clean_d = cl;
          ready_d = rdy;
          if (rdy) fault_d = 1'b0;
        end
        bad_d = win_ok ? '0 : ((bad_q == CNT_MAX) ? bad_q : bad_q + CNT_W'(1));
        res_d.ctrl_ready     = ready_d;
        res_d.fault_flag     = fault_d;
        res_d.inhibit_active = inh;
        res_d.bad_window_run = bad_d;
        res_d.min_khz        = min_q;
        res_d.max_khz        = max_q;
        out_valid_d          = 1'b1;
        state_d              = ST_OUT;
      end
      ST_OUT: begin
        if (result_o.ready) begin
          out_valid_d = 1'b0;
          win_open_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_open_q  <= 1'b0;
      start_q     <= '0;
      wsum_q      <= '0;
      dur_q       <= '0;
      smp_tot_q   <= '0;
      zero_tot_q  <= '0;
      min_q       <= '0;
      max_q       <= '0;
      clean_q     <= '0;
      bad_q       <= '0;
      fault_q     <= 1'b0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_open_q  <= win_open_d;
      start_q     <= start_d;
      wsum_q      <= wsum_d;
      dur_q       <= dur_d;
      smp_tot_q   <= smp_tot_d;
      zero_tot_q  <= zero_tot_d;
      min_q       <= min_d;
      max_q       <= max_d;
      clean_q     <= clean_d;
      bad_q       <= bad_d;
      fault_q     <= fault_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    prod_q  <= prod_d;
    close_q <= close_d;
    span_q  <= span_d;
    avg_q   <= avg_d;
    eprod_q <= eprod_d;
    kq_q    <= kq_d;
    ky_q    <= ky_d;
    res_q   <= res_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;

  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_OUT))
    else $error("result offered outside the output state");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV1))
    else $error("divider finished while nobody waits");

  a_ready_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ctrl_ready) |-> !res_q.fault_flag)
    else $error("fault latch left set on a control-ready window");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && q_valid_i))
    else $error("queue popped outside idle");

endmodule

### sv/gated_frequency_window_qualifier.sv
// flow: a sample that keeps its window open passes through the idle and accumulate states
// a closing sample goes on through close, the divider pass for the average (skipped at zero
// duration), the product, and the edge states for the division by 1000, then waits in output
// throughput: one sample at a time in the back end; the queue, two entries by default, stalls input when full
// reset: asynchronous, clears window and gate state and loads register defaults
// top level of the gated frequency window qualifier
module gated_frequency_window_qualifier #(
  parameter int QUEUE_DEPTH = gfwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gfwq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gfwq_pkg::CFG_W-1:0]       cfg_wdata_i,
  gfwq_stream_if.sink                      sample_i,
  gfwq_stream_if.source                    result_o
);
  import gfwq_pkg::*;

  // configuration registers; the user writes them only while the block is idle, the block does not enforce it
  cfg_t   cfg_q;
  logic   q_valid, q_pop;
  qent_t  q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_len_us         <= CFG_W'(1000000);
      cfg_q.inhibit_start_ms    <= '0;
      cfg_q.inhibit_len_ms      <= '0;
      cfg_q.ready_clean_windows <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GATE_PERIOD:   cfg_q.gate_len_us         <= cfg_wdata_i;
        CFG_INHIBIT_START: cfg_q.inhibit_start_ms    <= cfg_wdata_i;
        CFG_INHIBIT_LEN:   cfg_q.inhibit_len_ms      <= cfg_wdata_i;
        CFG_READY_CLEAN:   cfg_q.ready_clean_windows <= cfg_wdata_i;
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // front: takes sample transfers, works out each sample's duration and queues them
  gfwq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  // back: window sums, close check, divider pass and control gate
  gfwq_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

### test/gated_frequency_window_qualifier_test.sv
// self-checking testbench of the gated frequency window qualifier
module gated_frequency_window_qualifier_test;
  import gfwq_pkg::*;

  localparam logic [63:0] WSUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [39:0] DUR_MAX  = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;
  localparam longint unsigned TICK_MASK = 64'h0000_000F_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 2_000_000;

  // window statistics predictor with its own copy of the state
  class window_scoreboard;
    cfg_t            regs;
    bit              win_open;
    logic [35:0]     win_start;
    logic [63:0]     wsum;
    logic [39:0]     dur;
    logic [31:0]     n_smp, n_zero, clean_cnt, bad_cnt;
    logic [19:0]     lo_khz, hi_khz;
    bit              fault, ready_ctl;
    result_t         pending[$];
    int              errors;

    function void clear_win();
      win_open = 0; win_start = '0; wsum = '0; dur = '0;
      n_smp = '0; n_zero = '0; lo_khz = '0; hi_khz = '0;
    endfunction

    function void reset_all();
      regs.gate_len_us = 32'd1000000;
      regs.inhibit_start_ms = '0;
      regs.inhibit_len_ms = '0;
      regs.ready_clean_windows = 32'd1;
      clear_win();
      clean_cnt = '0; bad_cnt = '0; fault = 0; ready_ctl = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_GATE_PERIOD:   regs.gate_len_us = v;
        CFG_INHIBIT_START: regs.inhibit_start_ms = v;
        CFG_INHIBIT_LEN:   regs.inhibit_len_ms = v;
        CFG_READY_CLEAN:   regs.ready_clean_windows = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p[127:64] != 0) ? WSUM_MAX : p[63:0];
    endfunction

    // note one accepted sample; returns 1 when it closed a window
    function bit note_sample(sample_t s);
      logic [63:0] elapsed, prod, close_x, span, avg, edges;
      logic [64:0] wsum_n;
      logic [40:0] dur_n;
      logic [31:0] since;
      bit ok, inh;
      result_t r;
      if (!win_open) begin
        clear_win();
        win_start = s.sample_open_ticks;
        win_open = 1;
      end
      elapsed = ((64'(s.sample_close_ticks) - 64'(s.sample_open_ticks)) & TICK_MASK)
                / TICKS_PER_US;
      prod = sat_mul(64'(s.sample_khz), elapsed);
      wsum_n = 65'(wsum) + 65'(prod);
      wsum = wsum_n[64] ? WSUM_MAX : wsum_n[63:0];
      dur_n = 41'(dur) + 41'(elapsed);
      dur = (dur_n > 41'(DUR_MAX)) ? DUR_MAX : dur_n[39:0];
      if (n_smp == 0) begin
        lo_khz = s.sample_khz; hi_khz = s.sample_khz;
      end else begin
        if (s.sample_khz < lo_khz) lo_khz = s.sample_khz;
        if (s.sample_khz > hi_khz) hi_khz = s.sample_khz;
      end
      if (n_smp != CNT_MAX) n_smp++;
      if (s.sample_khz == 0 && n_zero != CNT_MAX) n_zero++;
      close_x = 64'(s.sample_close_ticks);
      if (close_x < 64'(win_start)) close_x += 64'd1 << TICK_WRAP_BITS;
      span = (close_x - 64'(win_start)) / TICKS_PER_US;
      if (span < 64'(regs.gate_len_us)) return 0;
      avg = (dur != 0) ? wsum / 64'(dur) : '0;
      if (avg > 64'hFFFFF) avg = 64'hFFFFF;
      edges = sat_mul(avg, span) / EDGE_DIVISOR;
      if (edges > 64'h3FF_FFFF_FFFF) edges = 64'h3FF_FFFF_FFFF;
      r.health_code = HEALTH_CLEAN;
      if (n_zero != 0) r.health_code = (n_zero == n_smp) ? HEALTH_ALL_ZERO : HEALTH_SOME_ZERO;
      ok = (n_smp != 0) && (n_zero == 0);
      since = s.now_ms - regs.inhibit_start_ms;
      inh = since < regs.inhibit_len_ms;
      if (!ok) begin
        clean_cnt = '0; ready_ctl = 0;
        if (!inh) fault = 1;
      end else if (inh) begin
        clean_cnt = '0; ready_ctl = 0;
      end else begin
        if (clean_cnt != CNT_MAX) clean_cnt++;
        ready_ctl = clean_cnt >= regs.ready_clean_windows;
        if (ready_ctl) fault = 0;
      end
      if (ok) bad_cnt = '0;
      else if (bad_cnt != CNT_MAX) bad_cnt++;
      r.window_open_ticks = win_start;
      r.window_close_ticks = close_x[36:0];
      r.edge_total = edges[41:0];
      r.average_khz = avg[19:0];
      r.span_us = span[32:0];
      r.ctrl_ready = ready_ctl;
      r.fault_flag = fault;
      r.inhibit_active = inh;
      r.bad_window_run = bad_cnt;
      r.min_khz = lo_khz;
      r.max_khz = hi_khz;
      pending.push_back(r);
      clear_win();
      return 1;
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.window_open_ticks !== e.window_open_ticks) begin
        $error("window_open_ticks exp %h got %h", e.window_open_ticks, got.window_open_ticks);
        errors++;
      end
      if (got.window_close_ticks !== e.window_close_ticks) begin
        $error("window_close_ticks exp %h got %h", e.window_close_ticks,
               got.window_close_ticks);
        errors++;
      end
      if (got.edge_total !== e.edge_total) begin
        $error("edge_total exp %0d got %0d", e.edge_total, got.edge_total);
        errors++;
      end
      if (got.average_khz !== e.average_khz) begin
        $error("average_khz exp %0d got %0d", e.average_khz, got.average_khz);
        errors++;
      end
      if (got.span_us !== e.span_us) begin
        $error("span_us exp %0d got %0d", e.span_us, got.span_us);
        errors++;
      end
      if (got.health_code !== e.health_code) begin
        $error("health_code exp %0d got %0d", e.health_code, got.health_code);
        errors++;
      end
      if (got.ctrl_ready !== e.ctrl_ready) begin
        $error("ctrl_ready exp %b got %b", e.ctrl_ready, got.ctrl_ready);
        errors++;
      end
      if (got.fault_flag !== e.fault_flag) begin
        $error("fault_flag exp %b got %b", e.fault_flag, got.fault_flag);
        errors++;
      end
      if (got.inhibit_active !== e.inhibit_active) begin
        $error("inhibit_active exp %b got %b", e.inhibit_active, got.inhibit_active);
        errors++;
      end
      if (got.bad_window_run !== e.bad_window_run) begin
        $error("bad_window_run exp %0d got %0d", e.bad_window_run, got.bad_window_run);
        errors++;
      end
      if (got.min_khz !== e.min_khz) begin
        $error("min_khz exp %0d got %0d", e.min_khz, got.min_khz);
        errors++;
      end
      if (got.max_khz !== e.max_khz) begin
        $error("max_khz exp %0d got %0d", e.max_khz, got.max_khz);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  gfwq_stream_if #(.T(sample_t)) sample_ch ();
  gfwq_stream_if #(.T(result_t)) result_ch ();

  gated_frequency_window_qualifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_ch.sink),
    .result_o    (result_ch.source)
  );

  window_scoreboard board;
  int  n_closed;
  int  n_sent;
  bit  calm;          // no idling in the closing stretch
  int  cycle_cnt;
  logic [35:0] tick_now;  // running tick stamp for well-formed sequences

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: generous bound over the slowest legal run
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: random back-pressure bursts, checked at the rising edge
  initial begin
    result_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      result_ch.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) board.check_result(result_ch.data);
  end

  // single register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.write_reg(idx, v);
  endtask

  // one sample transfer; caller is at a falling edge and returns at one
  // valid stays high until the next sample or drain replaces it
  task automatic send_sample(sample_t s);
    if (!calm && $urandom_range(0, 6) == 0) begin
      sample_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    sample_ch.valid <= 1;
    sample_ch.data <= s;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    n_closed += board.note_sample(s);
    n_sent++;
    @(negedge clk_i);
  endtask

  // caller is at a falling edge
  task automatic drain();
    sample_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    // a non-closing sample may still be in the back end
    repeat (100) @(negedge clk_i);
  endtask

  // well-formed sample: continues from the running tick stamp
  task automatic send_chained(logic [19:0] khz, int unsigned len_ticks, logic [31:0] now);
    sample_t s;
    s.sample_khz = khz;
    s.sample_open_ticks = tick_now;
    s.sample_close_ticks = tick_now + 36'(len_ticks);
    s.now_ms = now;
    tick_now = s.sample_close_ticks + 36'($urandom_range(0, 64));
    send_sample(s);
  endtask

  function automatic logic [19:0] rand_khz();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'd1000000;
      2: return 20'hFFFFF;
      3: return 20'($urandom_range(0, 15));
      default: return 20'($urandom_range(0, 1000000));
    endcase
  endfunction

  task automatic random_phase(int items, int unsigned max_len);
    sample_t s;
    repeat (items) begin
      if ($urandom_range(0, 9) == 0) begin
        // unordered noise stamps, across the whole field range
        s.sample_khz = 20'($urandom);
        s.sample_open_ticks = {4'($urandom), 32'($urandom)};
        s.sample_close_ticks = {4'($urandom), 32'($urandom)};
        s.now_ms = $urandom;
        send_sample(s);
      end else begin
        send_chained(($urandom_range(0, 3) == 0) ? 20'd0 : rand_khz(),
                     $urandom_range(0, max_len), $urandom);
      end
    end
  endtask

  initial begin
    sample_t s;
    board = new();
    board.reset_all();
    n_closed = 0; n_sent = 0; calm = 0;
    tick_now = 36'hF_FFFF_F000;  // wraps soon
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    sample_ch.valid = 0; sample_ch.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: zero gate period, every sample closes its own window
    write_reg(CFG_GATE_PERIOD, 32'd0);
    write_reg(CFG_READY_CLEAN, 32'd0);
    s = '{sample_khz: 20'hFFFFF, sample_open_ticks: 36'hF_FFFF_FFFF,
          sample_close_ticks: 36'h0, now_ms: 32'hFFFF_FFFF};
    send_sample(s);                 // close stamp below open: wrap
    s = '{sample_khz: 20'd0, sample_open_ticks: 36'h0,
          sample_close_ticks: 36'hF_FFFF_FFFF, now_ms: 32'h0};
    send_sample(s);                 // all-zero window, longest duration
    s = '{sample_khz: 20'd1000000, sample_open_ticks: 36'h1_0000,
          sample_close_ticks: 36'h1_0000, now_ms: 32'd5};
    send_sample(s);                 // zero duration, average zero
    send_chained(20'd1000000, 40000, 32'd6);
    drain();

    // directed: inhibit window wrapping past zero, clean windows in a row
    write_reg(CFG_GATE_PERIOD, 32'd100);
    write_reg(CFG_INHIBIT_START, 32'hFFFF_FFF0);
    write_reg(CFG_INHIBIT_LEN, 32'd100);
    write_reg(CFG_READY_CLEAN, 32'd2);
    send_chained(20'd500, 1000, 32'd10);           // inhibited, window stays open
    send_chained(20'd0, 1000, 32'd20);             // inhibited bad: closes the window with some zero
    send_chained(20'd7, 800, 32'd200);             // bad outside inhibit: fault
    send_chained(20'd0, 800, 32'd201);
    send_chained(20'd9, 2000, 32'd202);            // first clean window outside inhibit
    send_chained(20'd300, 2000, 32'd300);
    send_chained(20'd900, 2000, 32'd301);          // third clean: stays ready
    send_chained(20'd1000000, 1600, 32'd302);
    send_chained(20'd1, 1600, 32'd303);
    drain();

    // random: short gates, loose readiness
    write_reg(CFG_GATE_PERIOD, 32'd300);
    write_reg(CFG_READY_CLEAN, 32'd1);
    write_reg(CFG_INHIBIT_LEN, 32'd0);
    random_phase(180, 3000);
    drain();

    // random: long startup inhibit, demanding readiness
    write_reg(CFG_GATE_PERIOD, 32'd50);
    write_reg(CFG_INHIBIT_START, $urandom);
    write_reg(CFG_INHIBIT_LEN, 32'hFFFF_FFFF);
    write_reg(CFG_READY_CLEAN, 32'hFFFF_FFFF);
    write_reg(8'd7, $urandom);      // unmapped index, ignored
    random_phase(120, 1500);
    drain();

    // random: huge gate, windows close only when a span covers nearly the whole tick range
    write_reg(CFG_GATE_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_INHIBIT_LEN, 32'd500);
    write_reg(CFG_READY_CLEAN, 32'd3);
    random_phase(40, 5000);
    drain();
    write_reg(CFG_GATE_PERIOD, 32'd1);
    random_phase(60, 400);
    drain();

    // closing stretch without idling
    calm = 1;
    write_reg(CFG_GATE_PERIOD, 32'd200);
    write_reg(CFG_READY_CLEAN, 32'd1);
    random_phase(130, 2000);
    drain();

    $display("run covered %0d samples and %0d closed windows", n_sent, n_closed);
    $display("gate periods from zero to full range, inhibit and readiness extremes");
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
sv/gfwq_pkg.sv
sv/gfwq_stream_if.sv
sv/gfwq_front.sv
sv/gfwq_div.sv
sv/gfwq_back.sv
sv/gated_frequency_window_qualifier.sv
test/gated_frequency_window_qualifier_test.sv
